// File: sv/cfa_pkg.sv
// Shared constants and types of the contiguous fit allocator.
package cfa_pkg;

   // Geometry of the occupancy map; one memory word holds one cell.
   localparam int MAP_CELLS = 128;
   localparam int IDX_W     = $clog2(MAP_CELLS);
   localparam int LEN_W     = IDX_W + 1;

   // Field widths of the request, response and register words.
   localparam int SIZE_W   = 8;
   localparam int START_W  = 7;
   localparam int ADDR_W   = 7;
   localparam int HOLE_W   = 7;
   localparam int USED_W   = 8;
   localparam int POLICY_W = 2;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAP_CELLS - 1);

   // Search policy held in the configuration register.
   typedef enum logic [POLICY_W-1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_NEXT  = 2'd2,
      FIT_WORST = 2'd3
   } fit_policy_type;

   // Request operation codes.
   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

endpackage

// File: sv/contiguous_fit_allocator_unit.sv
// Top level of the contiguous fit allocator: occupancy memory, scan and update sequencer.
//
//   Channel    Handshake            Word carried
//   ---------  -------------------  ----------------------------------------------
//   request    start high, busy low  req_opcode, req_run_size, req_free_start
//   response   rsp_strobe (1 cycle)  rsp_granted_address, rsp_no_space,
//                                    rsp_hole_count, rsp_used_cells
//   register   csr_wr_en             csr_wr_data (fit policy)
//
// A free word takes one pass over the 128-entry occupancy memory, one cell per cycle, that
// rewrites the run and counts statistics, before its response strobe. An allocate word with a
// legal size takes a search pass over the memory, then the same update pass. The single read
// port of the occupancy memory keeps the two passes apart.
// After reset a clearing pass writes every cell free; busy stays high throughout it.
// The response is presented for exactly one cycle and cannot be held off; busy is already low
// in that cycle, so the next word may be accepted while the response is shown.
module contiguous_fit_allocator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_opcode,
   input  logic [cfa_pkg::SIZE_W-1:0]    req_run_size,
   input  logic [cfa_pkg::START_W-1:0]   req_free_start,
   output logic                          rsp_strobe,
   output logic [cfa_pkg::ADDR_W-1:0]    rsp_granted_address,
   output logic                          rsp_no_space,
   output logic [cfa_pkg::HOLE_W-1:0]    rsp_hole_count,
   output logic [cfa_pkg::USED_W-1:0]    rsp_used_cells,
   input  logic                          csr_wr_en,
   input  logic [cfa_pkg::POLICY_W-1:0]  csr_wr_data
);
   import cfa_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_UPDATE,
      ST_UPDATE_LAST
   } state_type;

   // Occupancy memory, one bit per cell, registered read.
   logic                   occ_mem [MAP_CELLS];
   logic                   rd_data_ff;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic                   mem_wdata;

   // Sequencer and pipeline control.
   state_type              state_ff;
   logic [IDX_W-1:0]       cnt_ff;
   logic                   pend_ff;
   logic [IDX_W-1:0]       pend_idx_ff;
   fit_policy_type         policy_ff;
   logic [IDX_W-1:0]       ptr_ff;

   // Latched request word.
   logic [SIZE_W-1:0]      size_ff;

   // Search state.
   logic [LEN_W-1:0]       run_ff;
   logic [LEN_W-1:0]       run_in;
   logic                   found_hi_ff;
   logic                   found_hi_in;
   logic [IDX_W-1:0]       addr_hi_ff;
   logic [IDX_W-1:0]       addr_hi_in;
   logic                   found_lo_ff;
   logic                   found_lo_in;
   logic [IDX_W-1:0]       addr_lo_ff;
   logic [IDX_W-1:0]       addr_lo_in;
   logic [LEN_W-1:0]       best_len_ff;
   logic [LEN_W-1:0]       best_len_in;

   // Update pass state.
   logic                   upd_en_ff;
   logic                   upd_val_ff;
   logic [IDX_W-1:0]       upd_start_ff;
   logic [SIZE_W-1:0]      upd_len_ff;
   logic [ADDR_W-1:0]      res_addr_ff;
   logic                   res_full_ff;
   logic [USED_W-1:0]      used_ff;
   logic [USED_W-1:0]      used_in;
   logic [HOLE_W-1:0]      holes_ff;
   logic [HOLE_W-1:0]      holes_in;
   logic                   prev_v_ff;

   // Registered response word.
   logic                   rsp_strobe_ff;
   logic [ADDR_W-1:0]      rsp_addr_ff;
   logic                   rsp_full_ff;
   logic [HOLE_W-1:0]      rsp_holes_ff;
   logic [USED_W-1:0]      rsp_used_ff;

   // Combinational helpers.
   logic                   scan_act;
   logic                   upd_act;
   logic                   scan_init;
   logic                   stat_clr;
   logic                   is_last;
   logic [IDX_W-1:0]       eff_ptr;
   logic [LEN_W-1:0]       run_base;
   logic [LEN_W-1:0]       run_new;
   logic [LEN_W-1:0]       size_len;
   logic [LEN_W-1:0]       lin_tmp;
   logic                   lin_hit;
   logic                   in_hi;
   logic [LEN_W-1:0]       hole_len;
   logic                   hole_evt;
   logic [IDX_W-1:0]       hole_addr;
   logic                   hole_take;
   logic                   grant_ok;
   logic [IDX_W-1:0]       grant_addr;
   logic [SIZE_W-1:0]      rel;
   logic                   in_run;
   logic                   new_v;
   logic                   size_ok;

   assign scan_act  = pend_ff && ((state_ff == ST_SCAN) || (state_ff == ST_SCAN_LAST));
   assign upd_act   = pend_ff && ((state_ff == ST_UPDATE) || (state_ff == ST_UPDATE_LAST));
   assign scan_init = (state_ff == ST_IDLE) && start;
   assign stat_clr  = scan_init || (state_ff == ST_SCAN_LAST);
   assign is_last   = (pend_idx_ff == LAST_IDX);
   assign size_ok   = (req_run_size != '0) && (req_run_size <= SIZE_W'(MAP_CELLS));

   // Per-cell search step; next fit splits the map at the pointer, the others start at zero.
   assign eff_ptr   = (policy_ff == FIT_NEXT) ? ptr_ff : '0;
   assign run_base  = (pend_idx_ff == eff_ptr) ? '0 : run_ff;
   assign run_new   = rd_data_ff ? '0 : run_base + 1'b1;
   assign size_len  = LEN_W'(size_ff);
   assign lin_hit   = !rd_data_ff && (run_new == size_len);
   assign lin_tmp   = LEN_W'(pend_idx_ff) + LEN_W'(1) - size_len;
   assign in_hi     = (pend_idx_ff >= eff_ptr);
   assign hole_len  = rd_data_ff ? run_ff : run_ff + 1'b1;
   assign hole_evt  = (rd_data_ff || is_last) && (hole_len != '0) && (hole_len >= size_len);
   assign hole_addr = pend_idx_ff - run_ff[IDX_W-1:0];
   assign hole_take = !found_hi_ff ||
                      ((policy_ff == FIT_WORST) ? (hole_len > best_len_ff)
                                                : (hole_len < best_len_ff));

   // The search state starts afresh when a word is accepted.
   always_comb begin
      run_in      = run_ff;
      found_hi_in = found_hi_ff;
      addr_hi_in  = addr_hi_ff;
      found_lo_in = found_lo_ff;
      addr_lo_in  = addr_lo_ff;
      best_len_in = best_len_ff;
      if (scan_init) begin
         run_in      = '0;
         found_hi_in = 1'b0;
         found_lo_in = 1'b0;
         best_len_in = '0;
      end else if (scan_act) begin
         run_in = run_new;
         if ((policy_ff == FIT_BEST) || (policy_ff == FIT_WORST)) begin
            if (hole_evt && hole_take) begin
               found_hi_in = 1'b1;
               addr_hi_in  = hole_addr;
               best_len_in = hole_len;
            end
         end else if (lin_hit) begin
            if (in_hi) begin
               if (!found_hi_ff) begin
                  found_hi_in = 1'b1;
                  addr_hi_in  = lin_tmp[IDX_W-1:0];
               end
            end else if (!found_lo_ff) begin
               found_lo_in = 1'b1;
               addr_lo_in  = lin_tmp[IDX_W-1:0];
            end
         end
      end
   end

   // A run found above the pointer wins over one found below it.
   assign grant_ok   = found_hi_in || found_lo_in;
   assign grant_addr = found_hi_in ? addr_hi_in : addr_lo_in;

   // Per-cell update step: rewrite cells inside the run and count statistics on the new map.
   assign rel    = SIZE_W'(pend_idx_ff) - SIZE_W'(upd_start_ff);
   assign in_run = upd_en_ff && (pend_idx_ff >= upd_start_ff) && (rel < upd_len_ff);
   assign new_v  = in_run ? upd_val_ff : rd_data_ff;

   // The counters are cleared before every update pass.
   always_comb begin
      used_in  = used_ff;
      holes_in = holes_ff;
      if (stat_clr) begin
         used_in  = '0;
         holes_in = '0;
      end else if (upd_act) begin
         used_in = used_ff + USED_W'(new_v);
         if (!new_v && ((pend_idx_ff == '0) || prev_v_ff)) begin
            holes_in = holes_ff + 1'b1;
         end
      end
   end

   // Memory write port: clearing pass after reset, otherwise the update pass.
   assign mem_we    = (state_ff == ST_CLEAR) || upd_act;
   assign mem_waddr = (state_ff == ST_CLEAR) ? cnt_ff : pend_idx_ff;
   assign mem_wdata = (state_ff == ST_CLEAR) ? 1'b0 : new_v;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         occ_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= occ_mem[cnt_ff];
   end

   // Sequencer with its datapath and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         pend_ff       <= 1'b0;
         policy_ff     <= FIT_FIRST;
         ptr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         pend_ff       <= (state_ff == ST_SCAN) || (state_ff == ST_UPDATE);
         pend_idx_ff   <= cnt_ff;
         rsp_strobe_ff <= (state_ff == ST_UPDATE_LAST);
         run_ff        <= run_in;
         found_hi_ff   <= found_hi_in;
         addr_hi_ff    <= addr_hi_in;
         found_lo_ff   <= found_lo_in;
         addr_lo_ff    <= addr_lo_in;
         best_len_ff   <= best_len_in;
         used_ff       <= used_in;
         holes_ff      <= holes_in;
         if (upd_act) begin
            prev_v_ff <= new_v;
         end
         if (csr_wr_en) begin
            policy_ff <= fit_policy_type'(csr_wr_data);
         end
         unique case (state_ff)
            ST_CLEAR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST_IDX) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  size_ff <= req_run_size;
                  cnt_ff  <= '0;
                  if (req_opcode == OP_FREE) begin
                     upd_en_ff    <= 1'b1;
                     upd_val_ff   <= 1'b0;
                     upd_start_ff <= req_free_start;
                     upd_len_ff   <= req_run_size;
                     res_addr_ff  <= '0;
                     res_full_ff  <= 1'b0;
                     state_ff     <= ST_UPDATE;
                  end else if (size_ok) begin
                     state_ff <= ST_SCAN;
                  end else begin
                     upd_en_ff   <= 1'b0;
                     res_addr_ff <= '0;
                     res_full_ff <= 1'b1;
                     ptr_ff      <= '0;
                     state_ff    <= ST_UPDATE;
                  end
               end
            end
            ST_SCAN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST_IDX) begin
                  state_ff <= ST_SCAN_LAST;
               end
            end
            ST_SCAN_LAST: begin
               cnt_ff <= '0;
               if (grant_ok) begin
                  upd_en_ff    <= 1'b1;
                  upd_val_ff   <= 1'b1;
                  upd_start_ff <= grant_addr;
                  upd_len_ff   <= size_ff;
                  res_addr_ff  <= ADDR_W'(grant_addr);
                  res_full_ff  <= 1'b0;
                  ptr_ff       <= grant_addr;
               end else begin
                  upd_en_ff   <= 1'b0;
                  res_addr_ff <= '0;
                  res_full_ff <= 1'b1;
                  ptr_ff      <= '0;
               end
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST_IDX) begin
                  state_ff <= ST_UPDATE_LAST;
               end
            end
            ST_UPDATE_LAST: begin
               rsp_addr_ff  <= res_addr_ff;
               rsp_full_ff  <= res_full_ff;
               rsp_holes_ff <= holes_in;
               rsp_used_ff  <= used_in;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_no_space        = rsp_full_ff;
   assign rsp_hole_count      = rsp_holes_ff;
   assign rsp_used_cells      = rsp_used_ff;

   // A response word only follows the last cell of an update pass.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_UPDATE_LAST))
      else $error("response strobe without a finished update pass");

   // A failed allocation never reports a granted address.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_full_ff) |-> (rsp_addr_ff == '0))
      else $error("no_space response carries a non-zero address");

   // The update pass never writes the cell that it is reading in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      upd_act |-> (mem_waddr != cnt_ff))
      else $error("update pass writes the entry under read");

   // Statistics stay within the size of the map.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> ((rsp_used_ff <= USED_W'(MAP_CELLS)) &&
                         (rsp_holes_ff <= HOLE_W'(MAP_CELLS / 2))))
      else $error("response statistics exceed the map size");

   // The block only goes idle after a response or at the end of the clearing pass.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_strobe_ff || $past(state_ff == ST_CLEAR)))
      else $error("busy dropped without a response");

endmodule
